### src/fpat_pkg.sv
// Shared types, constants and step tables for the flash page address translator.
// No dependencies; every other file imports this package.
package fpat_pkg;

  localparam int FlatW  = 32;
  localparam int ChW    = 8;
  localparam int IdxW   = 4;
  localparam int BlkW   = 12;
  localparam int PageW  = 10;
  localparam int SzW    = 39;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  // quotient widths of the successive divisions
  localparam int ChQ  = 32;
  localparam int SubQ = 5;
  localparam int BlkQ = 13;
  localparam int NumSteps = ChQ + 3 * SubQ + BlkQ;
  localparam int TrialW = SzW + FlatW + 1;

  localparam logic REQ_DECOMPOSE = 1'b0;
  localparam logic REQ_COMPOSE   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PPB = 8'd0,
    REG_BPP = 8'd1,
    REG_PPD = 8'd2,
    REG_DPC = 8'd3,
    REG_CPC = 8'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DIV_CHAN  = 3'd0,
    DIV_CHIP  = 3'd1,
    DIV_DIE   = 3'd2,
    DIV_PLANE = 3'd3,
    DIV_BLK   = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic [SzW-1:0] chan;
    logic [SzW-1:0] chip;
    logic [SzW-1:0] die;
    logic [SzW-1:0] plane;
    logic [SzW-1:0] blk;
  } sizes_t;

  typedef struct packed {
    logic             req_type;
    logic [FlatW-1:0] flat;
    logic [ChW-1:0]   ch;
    logic [IdxW-1:0]  chip;
    logic [IdxW-1:0]  die;
    logic [IdxW-1:0]  plane;
    logic [BlkW-1:0]  block;
    logic [PageW-1:0] page;
    logic [FlatW-1:0] rem;
    logic [ChQ-1:0]   q_ch;
    logic [SubQ-1:0]  q_chip;
    logic [SubQ-1:0]  q_die;
    logic [SubQ-1:0]  q_plane;
    logic [BlkQ-1:0]  q_blk;
    logic [5:0][FlatW-1:0] prod;
  } pipe_t;

  function automatic div_sel_t step_sel(input int s);
    div_sel_t r;
    if (s < ChQ) r = DIV_CHAN;
    else if (s < ChQ + SubQ) r = DIV_CHIP;
    else if (s < ChQ + 2 * SubQ) r = DIV_DIE;
    else if (s < ChQ + 3 * SubQ) r = DIV_PLANE;
    else r = DIV_BLK;
    return r;
  endfunction

  function automatic int step_shift(input int s);
    int r;
    if (s < ChQ) r = ChQ - 1 - s;
    else if (s < ChQ + SubQ) r = ChQ + SubQ - 1 - s;
    else if (s < ChQ + 2 * SubQ) r = ChQ + 2 * SubQ - 1 - s;
    else if (s < ChQ + 3 * SubQ) r = ChQ + 3 * SubQ - 1 - s;
    else r = NumSteps - 1 - s;
    return r;
  endfunction

endpackage

### src/fpat_req_if.sv
// Request channel: valid/ready handshake and the request payload.
// Depends on fpat_pkg for field widths.
interface fpat_req_if;
  import fpat_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [FlatW-1:0] flat_page;
  logic [ChW-1:0]   in_channel;
  logic [IdxW-1:0]  in_chip;
  logic [IdxW-1:0]  in_die;
  logic [IdxW-1:0]  in_plane;
  logic [BlkW-1:0]  in_block;
  logic [PageW-1:0] in_page;
  modport source (output valid, req_type, flat_page, in_channel, in_chip, in_die,
                  in_plane, in_block, in_page, input ready);
  modport sink (input valid, req_type, flat_page, in_channel, in_chip, in_die,
                in_plane, in_block, in_page, output ready);
endinterface

### src/fpat_rsp_if.sv
// Response channel: valid/ready handshake and the translated address payload.
// Depends on fpat_pkg for field widths.
interface fpat_rsp_if;
  import fpat_pkg::*;
  logic             valid;
  logic             ready;
  logic [FlatW-1:0] out_flat_page;
  logic [ChW-1:0]   out_channel;
  logic [IdxW-1:0]  out_chip;
  logic [IdxW-1:0]  out_die;
  logic [IdxW-1:0]  out_plane;
  logic [BlkW-1:0]  out_block;
  logic [PageW-1:0] out_page;
  logic             out_of_range;
  modport source (output valid, out_flat_page, out_channel, out_chip, out_die,
                  out_plane, out_block, out_page, out_of_range, input ready);
  modport sink (input valid, out_flat_page, out_channel, out_chip, out_die,
                out_plane, out_block, out_page, out_of_range, output ready);
endinterface

### src/fpat_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on fpat_pkg for widths.
interface fpat_cfg_if;
  import fpat_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/fpat_cfg.sv
// Geometry registers and the registered multiply chain that forms the unit sizes.
// Depends on fpat_pkg and fpat_cfg_if.
module fpat_cfg (
  input  logic             clk,
  input  logic             rst,
  fpat_cfg_if.sink         cfg,
  output fpat_pkg::sizes_t sizes,
  output logic             settled
);
  import fpat_pkg::*;

  logic [10:0] ppb;
  logic [12:0] bpp;
  logic [4:0]  ppd;
  logic [4:0]  dpc;
  logic [4:0]  cpc;
  logic [10:0] blk_sz;
  logic [23:0] plane_sz;
  logic [28:0] die_sz;
  logic [33:0] chip_sz;
  logic [38:0] chan_sz;
  logic [2:0]  settle;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppb    <= 11'd64;
      bpp    <= 13'd2048;
      ppd    <= 5'd2;
      dpc    <= 5'd1;
      cpc    <= 5'd4;
      settle <= 3'd5;
    end else if (cfg.valid) begin
      settle <= 3'd5;
      case (cfg.index)
        REG_PPB: ppb <= cfg.data[10:0];
        REG_BPP: bpp <= cfg.data[12:0];
        REG_PPD: ppd <= cfg.data[4:0];
        REG_DPC: dpc <= cfg.data[4:0];
        REG_CPC: cpc <= cfg.data[4:0];
        default: ;
      endcase
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  // zero counts as one; one multiply per register after the block size
  always_ff @(posedge clk) begin
    blk_sz   <= (ppb == 11'd0) ? 11'd1 : ppb;
    plane_sz <= 24'(blk_sz) * 24'((bpp == 13'd0) ? 13'd1 : bpp);
    die_sz   <= 29'(plane_sz) * 29'((ppd == 5'd0) ? 5'd1 : ppd);
    chip_sz  <= 34'(die_sz) * 34'((dpc == 5'd0) ? 5'd1 : dpc);
    chan_sz  <= 39'(chip_sz) * 39'((cpc == 5'd0) ? 5'd1 : cpc);
  end

  assign sizes.blk   = SzW'(blk_sz);
  assign sizes.plane = SzW'(plane_sz);
  assign sizes.die   = SzW'(die_sz);
  assign sizes.chip  = SzW'(chip_sz);
  assign sizes.chan  = chan_sz;
  assign settled     = (settle == 3'd0);

endmodule

### src/fpat_pipe.sv
// Division/sum pipeline: one restoring-division step per stage, compose sum in the
// first three stages. Depends on fpat_pkg.
module fpat_pipe (
  input  logic             clk,
  input  logic             rst,
  input  fpat_pkg::sizes_t sizes,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpat_pkg::pipe_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fpat_pkg::pipe_t  out_data
);
  import fpat_pkg::*;

  pipe_t st [NumSteps+1];
  logic [NumSteps:0]   v;
  logic [NumSteps+1:1] rdy;

  assign st[0] = in_data;
  assign v[0]  = in_valid;
  assign rdy[NumSteps+1] = out_ready;
  assign in_ready = rdy[1];

  for (genvar k = 1; k <= NumSteps; k++) begin : g_stage
    localparam div_sel_t Sel = step_sel(k - 1);
    localparam int       Sh  = step_shift(k - 1);
    logic [SzW-1:0]    d;
    logic [TrialW-1:0] trial;
    logic              fits;
    pipe_t             nxt;

    assign rdy[k] = !v[k] || rdy[k+1];

    always_comb begin
      case (Sel)
        DIV_CHAN:  d = sizes.chan;
        DIV_CHIP:  d = sizes.chip;
        DIV_DIE:   d = sizes.die;
        DIV_PLANE: d = sizes.plane;
        default:   d = sizes.blk;
      endcase
      trial = TrialW'(d) << Sh;
      fits  = (trial[TrialW-1:FlatW] == '0) && (st[k-1].rem >= trial[FlatW-1:0]);
      nxt   = st[k-1];
      if (fits) nxt.rem = st[k-1].rem - trial[FlatW-1:0];
      case (Sel)
        DIV_CHAN:  nxt.q_ch    = {st[k-1].q_ch[ChQ-2:0], fits};
        DIV_CHIP:  nxt.q_chip  = {st[k-1].q_chip[SubQ-2:0], fits};
        DIV_DIE:   nxt.q_die   = {st[k-1].q_die[SubQ-2:0], fits};
        DIV_PLANE: nxt.q_plane = {st[k-1].q_plane[SubQ-2:0], fits};
        default:   nxt.q_blk   = {st[k-1].q_blk[BlkQ-2:0], fits};
      endcase
      // compose: products, then pairwise adds, then the final add
      if (k == 1) begin
        nxt.prod[0] = 32'(st[0].ch) * sizes.chan[FlatW-1:0];
        nxt.prod[1] = 32'(st[0].chip) * sizes.chip[FlatW-1:0];
        nxt.prod[2] = 32'(st[0].die) * sizes.die[FlatW-1:0];
        nxt.prod[3] = 32'(st[0].plane) * sizes.plane[FlatW-1:0];
        nxt.prod[4] = 32'(st[0].block) * 32'(sizes.blk[10:0]);
        nxt.prod[5] = 32'(st[0].page);
      end else if (k == 2) begin
        nxt.prod[0] = st[k-1].prod[0] + st[k-1].prod[1];
        nxt.prod[1] = st[k-1].prod[2] + st[k-1].prod[3];
        nxt.prod[2] = st[k-1].prod[4] + st[k-1].prod[5];
      end else if (k == 3) begin
        nxt.prod[0] = st[k-1].prod[0] + st[k-1].prod[1] + st[k-1].prod[2];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v[k-1]) st[k] <= nxt;
    end
  end

  assign out_valid = v[NumSteps];
  assign out_data  = st[NumSteps];

  a_rem_lt_blk: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.req_type == REQ_DECOMPOSE
      |-> SzW'(out_data.rem) < sizes.blk)
    else $error("final remainder not below block size");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output stage lost or changed a held result");

endmodule

### src/flash_page_address_translator_unit.sv
// Top level of the flash page address translator: config block plus step pipeline.
// Depends on fpat_pkg, the three channel interfaces, fpat_cfg and fpat_pipe.
//
//   channel | modport | carries
//   --------+---------+-------------------------------------------------
//   req     | sink    | req_type, flat_page, in_channel .. in_page
//   rsp     | source  | out_flat_page, out_channel .. out_page, out_of_range
//   cfg     | sink    | index, data (geometry register writes)
//
// A request passes 60 register stages, one restoring-division step per stage over
// 32 channel, 3x5 chip/die/plane and 13 block quotient bits.
// One request enters per cycle while the sizes are settled and the first stage is free;
// the compose sum rides along in the first stages. rst is synchronous; after reset
// or any config write, requests are held off while the size multiply chain settles.
// Each stage holds its request when the next one is full and stalled; empty
// stages keep filling, so requests are taken while a result waits at rsp.
module flash_page_address_translator_unit (
  input  logic      clk,
  input  logic      rst,
  fpat_req_if.sink  req,
  fpat_rsp_if.source rsp,
  fpat_cfg_if.sink  cfg
);
  import fpat_pkg::*;

  sizes_t sizes;
  logic   settled;
  logic   pipe_ready;
  pipe_t  in_data;
  pipe_t  out_data;
  logic   ch_over;

  fpat_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .sizes   (sizes),
    .settled (settled)
  );

  // pack the request; the remainder starts as the flat page
  always_comb begin
    in_data          = '0;
    in_data.req_type = req.req_type;
    in_data.flat     = req.flat_page;
    in_data.ch       = req.in_channel;
    in_data.chip     = req.in_chip;
    in_data.die      = req.in_die;
    in_data.plane    = req.in_plane;
    in_data.block    = req.in_block;
    in_data.page     = req.in_page;
    in_data.rem      = req.flat_page;
  end

  // hold off requests until the sizes are valid
  assign req.ready = pipe_ready && settled;

  fpat_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .sizes     (sizes),
    .in_valid  (req.valid && settled),
    .in_ready  (pipe_ready),
    .in_data   (in_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (out_data)
  );

  // saturate the channel quotient on decompose; echo coordinates on compose
  assign ch_over = (out_data.q_ch[ChQ-1:ChW] != '0);

  always_comb begin
    if (out_data.req_type == REQ_COMPOSE) begin
      rsp.out_flat_page = out_data.prod[0];
      rsp.out_channel   = out_data.ch;
      rsp.out_chip      = out_data.chip;
      rsp.out_die       = out_data.die;
      rsp.out_plane     = out_data.plane;
      rsp.out_block     = out_data.block;
      rsp.out_page      = out_data.page;
      rsp.out_of_range  = 1'b0;
    end else begin
      rsp.out_flat_page = out_data.flat;
      rsp.out_channel   = ch_over ? '1 : out_data.q_ch[ChW-1:0];
      rsp.out_chip      = out_data.q_chip[IdxW-1:0];
      rsp.out_die       = out_data.q_die[IdxW-1:0];
      rsp.out_plane     = out_data.q_plane[IdxW-1:0];
      rsp.out_block     = out_data.q_blk[BlkW-1:0];
      rsp.out_page      = out_data.rem[PageW-1:0];
      rsp.out_of_range  = ch_over;
    end
  end

  a_no_accept_unsettled: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> settled)
    else $error("request accepted while sizes were settling");

endmodule
